FILE: src/phong_smith_shadowing_g1_unit_assert.svh
// Assertion macros shared by the shadowing unit.
`ifndef PHONG_SMITH_SHADOWING_G1_UNIT_ASSERT_SVH
`define PHONG_SMITH_SHADOWING_G1_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PSHG1_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("pshg1 assertion failed");
`define PSHG1_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
   else $error("pshg1 reset assertion failed");
`else
`define PSHG1_ASSERT(lbl, clk, rst, prop)
`define PSHG1_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: src/pshg1_pkg.sv
package pshg1_pkg;

   localparam int PHONG_W = 24;
   localparam logic [PHONG_W-1:0] PHONG_RESET = 24'd256;
   localparam logic [24:0] K_OFFSET = 25'd512;

   // Rational approximation coefficients, Q.16
   localparam logic [17:0] CF_LIN_NUM = 18'd231670;
   localparam logic [17:0] CF_SQ_NUM  = 18'd142934;
   localparam logic [17:0] CF_LIN_DEN = 18'd181338;
   localparam logic [17:0] CF_SQ_DEN  = 18'd168886;

   typedef enum logic [1:0] {
      CODE_BACK = 2'd0,
      CODE_SAT  = 2'd1,
      CODE_WIDE = 2'd2,
      CODE_RAT  = 2'd3
   } case_code_type;

   typedef struct packed {
      logic signed [15:0] view_x;
      logic signed [15:0] view_y;
      logic signed [15:0] view_z;
      logic signed [15:0] micro_x;
      logic signed [15:0] micro_y;
      logic signed [15:0] micro_z;
      logic signed [15:0] surf_x;
      logic signed [15:0] surf_y;
      logic signed [15:0] surf_z;
   } req_type;

   typedef struct packed {
      logic [15:0] shadow_factor;
      logic [1:0]  case_code;
   } rsp_type;

endpackage

FILE: src/phong_smith_shadowing_g1_unit.sv
// Throughput: one request per cycle while no result is held; the two restoring dividers and the square
// root retire one bit per stage, and the whole pipe advances together.
// A stalled result holds every stage; ready is low only while it is held.
// Reset (synchronous, active high) empties the pipe and sets the exponent to 1.0.
`include "phong_smith_shadowing_g1_unit_assert.svh"
module phong_smith_shadowing_g1_unit
   import pshg1_pkg::*;
#(
   parameter int VEC_FRAC_BITS = 14,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_payload,
   input  logic               csr_write_enable,
   input  logic [PHONG_W-1:0] csr_write_data
);

   localparam logic [OUT_FRAC_BITS+16:0] ONE_WIDE = (OUT_FRAC_BITS+17)'(1) << OUT_FRAC_BITS;
   localparam logic [15:0] ONE16 = ONE_WIDE[15:0];

   logic [PHONG_W-1:0] phong_ff;
   logic               en;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic          f_valid;
   logic [56:0]   f_n;
   logic [32:0]   f_q;
   case_code_type f_code;

   logic          d1_valid;
   logic [33:0]   d1_quo;
   logic [1:0]    d1_side;

   logic          s_valid;
   logic [16:0]   s_root;
   logic [1:0]    s_side;

   logic          b_valid;
   logic [36:0]   b_num, b_den;
   case_code_type b_code;

   logic                     d2_valid;
   logic [OUT_FRAC_BITS-1:0] d2_quo;
   logic [1:0]               d2_side;
   logic [OUT_FRAC_BITS+15:0] quo_ext;

   // advance the whole pipe unless a result is held
   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         phong_ff <= PHONG_RESET;
      end else if (csr_write_enable) begin
         phong_ff <= csr_write_data;
      end
   end

   pshg1_front #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid && req_ready), .in_data(req_payload), .phong(phong_ff),
      .out_valid(f_valid), .out_n(f_n), .out_q(f_q), .out_code(f_code)
   );

   pshg1_divider #(.NUM_W(80), .DEN_W(33), .QUO_W(34), .SIDE_W(2)) u_div_a2 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(f_valid), .in_num({f_n, 23'd0}), .in_den(f_q), .in_side(f_code),
      .out_valid(d1_valid), .out_quo(d1_quo), .out_side(d1_side)
   );

   pshg1_isqrt #(.RAD_W(34), .SIDE_W(2)) u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(d1_valid), .in_rad(d1_quo), .in_side(d1_side),
      .out_valid(s_valid), .out_root(s_root), .out_side(s_side)
   );

   pshg1_back u_back (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s_valid), .in_a(s_root), .in_code(case_code_type'(s_side)),
      .out_valid(b_valid), .out_num(b_num), .out_den(b_den), .out_code(b_code)
   );

   pshg1_divider #(
      .NUM_W(37 + OUT_FRAC_BITS), .DEN_W(37), .QUO_W(OUT_FRAC_BITS), .SIDE_W(2)
   ) u_div_ratio (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(b_valid), .in_num({b_num, OUT_FRAC_BITS'(0)}), .in_den(b_den),
      .in_side(b_code),
      .out_valid(d2_valid), .out_quo(d2_quo), .out_side(d2_side)
   );

   always_comb begin
      quo_ext = (OUT_FRAC_BITS+16)'(d2_quo);
      rsp_in.case_code = d2_side;
      unique case (case_code_type'(d2_side))
         CODE_BACK: rsp_in.shadow_factor = 16'd0;
         CODE_SAT:  rsp_in.shadow_factor = ONE16;
         CODE_WIDE: rsp_in.shadow_factor = ONE16;
         CODE_RAT:  rsp_in.shadow_factor = quo_ext[15:0];
         default:   rsp_in.shadow_factor = 16'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `PSHG1_ASSERT(a_back_zero, clock, reset, rsp_valid && rsp_payload.case_code == CODE_BACK |-> rsp_payload.shadow_factor == 16'd0)
   `PSHG1_ASSERT(a_sat_one, clock, reset, rsp_valid && (rsp_payload.case_code == CODE_SAT || rsp_payload.case_code == CODE_WIDE) |-> rsp_payload.shadow_factor == ONE16)
   `PSHG1_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid && req_ready)

endmodule

FILE: src/pshg1_front.sv
module pshg1_front
   import pshg1_pkg::*;
#(
   parameter int VEC_FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  req_type              in_data,
   input  logic [PHONG_W-1:0]   phong,
   output logic                 out_valid,
   output logic [56:0]          out_n,
   output logic [32:0]          out_q,
   output case_code_type        out_code
);

   localparam logic [63:0] DOT_ONE = 64'd1 << (2 * VEC_FRAC_BITS);

   logic [5:0] v_ff;

   logic signed [31:0] p_ff [6];
   logic signed [33:0] mv_ff, vn_ff;
   logic [15:0]        c_ff;
   case_code_type      code3_ff, code4_ff, code5_ff, code6_ff;
   logic [31:0]        c2_ff;
   logic [32:0]        q4_ff, q5_ff, q6_ff;
   logic [56:0]        n5_ff, n6_ff;

   logic               back;
   logic [33:0]        mag, mag_sh;
   logic [63:0]        mag_ext;
   case_code_type      code3_in, code6_in;
   logic [24:0]        k;
   logic [61:0]        big, qbig;

   always_comb begin
      back = (mv_ff < 0 && vn_ff >= 0) || (mv_ff > 0 && vn_ff < 0);
      mag = (mv_ff < 0) ? 34'(-mv_ff) : 34'(mv_ff);
      mag_ext = 64'(mag);
      mag_sh = mag >> (2 * VEC_FRAC_BITS - 16);
      if (back) begin
         code3_in = CODE_BACK;
      end else if (mag_ext >= DOT_ONE) begin
         code3_in = CODE_SAT;
      end else begin
         code3_in = CODE_RAT;
      end
      k = 25'(phong) + K_OFFSET;
      big = (62'(n5_ff) << 4) + (62'(n5_ff) << 3) + 62'(n5_ff);
      qbig = 62'(q5_ff) << 15;
      code6_in = (code5_ff == CODE_RAT && big >= qbig) ? CODE_WIDE : code5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= in_data.micro_x * in_data.view_x;
         p_ff[1] <= in_data.micro_y * in_data.view_y;
         p_ff[2] <= in_data.micro_z * in_data.view_z;
         p_ff[3] <= in_data.view_x * in_data.surf_x;
         p_ff[4] <= in_data.view_y * in_data.surf_y;
         p_ff[5] <= in_data.view_z * in_data.surf_z;
         mv_ff <= 34'(p_ff[0]) + 34'(p_ff[1]) + 34'(p_ff[2]);
         vn_ff <= 34'(p_ff[3]) + 34'(p_ff[4]) + 34'(p_ff[5]);
         c_ff <= mag_sh[15:0];
         code3_ff <= code3_in;
         c2_ff <= c_ff * c_ff;
         q4_ff <= 33'h1_0000_0000 - 33'(c_ff * c_ff);
         code4_ff <= code3_ff;
         n5_ff <= 57'(c2_ff) * 57'(k);
         q5_ff <= q4_ff;
         code5_ff <= code4_ff;
         n6_ff <= n5_ff;
         q6_ff <= q5_ff;
         code6_ff <= code6_in;
      end
   end

   assign out_valid = v_ff[5];
   assign out_n = n6_ff;
   assign out_q = q6_ff;
   assign out_code = code6_ff;

endmodule

FILE: src/pshg1_divider.sv
module pshg1_divider
   import pshg1_pkg::*;
#(
   parameter int NUM_W  = 80,
   parameter int DEN_W  = 33,
   parameter int QUO_W  = 34,
   parameter int SIDE_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              v_ff    [QUO_W+1];
   logic [DEN_W-1:0]  rem_ff  [QUO_W+1];
   logic [QUO_W-1:0]  low_ff  [QUO_W+1];
   logic [QUO_W-1:0]  quo_ff  [QUO_W+1];
   logic [DEN_W-1:0]  den_ff  [QUO_W+1];
   logic [SIDE_W-1:0] side_ff [QUO_W+1];

   logic [NUM_W-1:0]  num_hi;
   assign num_hi = in_num >> QUO_W;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num_hi[DEN_W-1:0];
         low_ff[0]  <= in_num[QUO_W-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      logic [DEN_W:0] trial, diff;
      logic           ge;
      always_comb begin
         trial = {rem_ff[s], low_ff[s][QUO_W-1]};
         diff  = trial - {1'b0, den_ff[s]};
         ge    = trial >= {1'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_ff[s+1]  <= low_ff[s] << 1;
            quo_ff[s+1]  <= (quo_ff[s] << 1) | QUO_W'(ge);
            den_ff[s+1]  <= den_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

   logic unused_tail;
   assign unused_tail = ^{rem_ff[QUO_W], low_ff[QUO_W], den_ff[QUO_W]};

endmodule

FILE: src/pshg1_isqrt.sv
module pshg1_isqrt
   import pshg1_pkg::*;
#(
   parameter int RAD_W  = 34,
   parameter int SIDE_W = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int ROOT_W = RAD_W / 2;

   logic              v_ff    [ROOT_W+1];
   logic [ROOT_W+1:0] rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W+1];
   logic [SIDE_W-1:0] side_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rad_ff[0]  <= in_rad;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < ROOT_W; s++) begin : g_step
      logic [ROOT_W+3:0] r2, t, diff;
      logic              ge;
      always_comb begin
         r2   = {rem_ff[s], rad_ff[s][RAD_W-1 -: 2]};
         t    = (ROOT_W+4)'({root_ff[s], 2'b01});
         diff = r2 - t;
         ge   = r2 >= t;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1]  <= ge ? diff[ROOT_W+1:0] : r2[ROOT_W+1:0];
            root_ff[s+1] <= (root_ff[s] << 1) | ROOT_W'(ge);
            rad_ff[s+1]  <= rad_ff[s] << 2;
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

   logic unused_tail;
   assign unused_tail = ^{rem_ff[ROOT_W], rad_ff[ROOT_W]};

endmodule

FILE: src/pshg1_back.sv
module pshg1_back
   import pshg1_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [16:0]   in_a,
   input  case_code_type in_code,
   output logic          out_valid,
   output logic [36:0]   out_num,
   output logic [36:0]   out_den,
   output case_code_type out_code
);

   logic [2:0]    v_ff;
   logic [33:0]   aa_ff;
   logic [34:0]   l1_ff, l3_ff, l1b_ff, l3b_ff;
   logic [51:0]   s2_ff, s4_ff;
   logic [36:0]   num_ff, den_ff;
   case_code_type code1_ff, code2_ff, code3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aa_ff    <= in_a * in_a;
         l1_ff    <= CF_LIN_NUM * in_a;
         l3_ff    <= CF_LIN_DEN * in_a;
         code1_ff <= in_code;
         s2_ff    <= 52'(CF_SQ_NUM) * 52'(aa_ff);
         s4_ff    <= 52'(CF_SQ_DEN) * 52'(aa_ff);
         l1b_ff   <= l1_ff;
         l3b_ff   <= l3_ff;
         code2_ff <= code1_ff;
         num_ff   <= 37'(l1b_ff) + 37'(s2_ff >> 16);
         den_ff   <= 37'h1_0000_0000 + 37'(l3b_ff) + 37'(s4_ff >> 16);
         code3_ff <= code2_ff;
      end
   end

   assign out_valid = v_ff[2];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_code  = code3_ff;

endmodule

FILE: verif/tb_top.sv
module tb_top;
   import pshg1_pkg::*;

   localparam int LATENCY = 79;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [PHONG_W-1:0] csr_write_data = '0;

   phong_smith_shadowing_g1_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   req_type pending_reqs[$];
   rsp_type expected_shadows[$];
   logic [PHONG_W-1:0] exponent_q = PHONG_RESET;
   int fail_count = 0;
   bit quiet = 0;
   bit hold_rsp = 0;
   int hold_cycles = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   initial forever #2 clock = ~clock;

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [63:0] root64(logic [63:0] x);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic rsp_type shadow_of(req_type r, logic [PHONG_W-1:0] p);
      rsp_type o;
      longint mv, vn;
      logic [63:0] mag, c, c2, q, k, n, a2, a, aa, num, den, f;
      mv = longint'(r.micro_x) * r.view_x + longint'(r.micro_y) * r.view_y
         + longint'(r.micro_z) * r.view_z;
      vn = longint'(r.view_x) * r.surf_x + longint'(r.view_y) * r.surf_y
         + longint'(r.view_z) * r.surf_z;
      if ((mv < 0 && vn >= 0) || (mv > 0 && vn < 0)) begin
         o.shadow_factor = 0;
         o.case_code = CODE_BACK;
      end else begin
         mag = (mv < 0) ? -mv : mv;
         if (mag >= (64'd1 << 28)) begin
            o.shadow_factor = 16'h8000;
            o.case_code = CODE_SAT;
         end else begin
            c = (mag >> 12) & 64'hFFFF;
            c2 = c * c;
            q = (64'd1 << 32) - c2;
            k = 64'(p) + 64'd512;
            n = c2 * k;
            if (n * 25 >= q * 32768) begin
               o.shadow_factor = 16'h8000;
               o.case_code = CODE_WIDE;
            end else begin
               a2 = ((n / q) << 23) + (((n % q) << 23) / q);
               a = root64(a2);
               aa = a * a;
               num = 64'(CF_LIN_NUM) * a + ((64'(CF_SQ_NUM) * aa) >> 16);
               den = (64'd1 << 32) + 64'(CF_LIN_DEN) * a + ((64'(CF_SQ_DEN) * aa) >> 16);
               f = (num << 15) / den;
               o.shadow_factor = f[15:0];
               o.case_code = CODE_RAT;
            end
         end
      end
      return o;
   endfunction

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(0, 9))
         0: return 16'($urandom());
         1: return 16'sd16384;
         2: return -16'sd16384;
         3: return 16'sd0;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type r;
      r.view_x = rand_comp(); r.view_y = rand_comp(); r.view_z = rand_comp();
      r.micro_x = rand_comp(); r.micro_y = rand_comp(); r.micro_z = rand_comp();
      r.surf_x = rand_comp(); r.surf_y = rand_comp(); r.surf_z = rand_comp();
      // bias half towards front-facing, modest |m.v| to reach the rational path
      if ($urandom_range(0, 1)) begin
         r.view_y = 0; r.view_z = 0; r.micro_y = 0; r.micro_z = 0;
         r.view_x = 16'($urandom_range(0, 16384));
         r.micro_x = 16'($urandom_range(0, 16384));
         r.surf_x = 16'($urandom_range(1, 16384));
      end
      return r;
   endfunction

   function automatic req_type vec3(int vx, int mx, int nx, int vy = 0, int my = 0);
      req_type r;
      r = '0;
      r.view_x = 16'(vx); r.micro_x = 16'(mx); r.surf_x = 16'(nx);
      r.view_y = 16'(vy); r.micro_y = 16'(my);
      return r;
   endfunction

   // Driver: push requests, predict on acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_shadows.push_back(shadow_of(req_payload, exponent_q));
            void'(pending_reqs.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            req_gap <= $urandom_range(1, 14);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > (req_valid && req_ready ? 1 : 0)) begin
            req_valid <= 1'b1;
            req_payload <= (req_valid && req_ready) ? pending_reqs[1] : pending_reqs[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare results, stall the result side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_shadows.size() == 0) begin
               $error("unexpected result %h", rsp_payload);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_shadows.pop_front();
               if (rsp_payload.shadow_factor !== e.shadow_factor) begin
                  $error("shadow_factor expected %0d actual %0d",
                         e.shadow_factor, rsp_payload.shadow_factor);
                  fail_count++;
               end
               if (rsp_payload.case_code !== e.case_code) begin
                  $error("case_code expected %0d actual %0d",
                         e.case_code, rsp_payload.case_code);
                  fail_count++;
               end
            end
         end
         if (hold_rsp) begin
            hold_cycles <= hold_cycles + 1;
            rsp_ready <= 1'b0;
            if (hold_cycles >= 300) hold_rsp <= 0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_gap <= $urandom_range(1, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic drain();
      int guard;
      guard = 0;
      while ((pending_reqs.size() != 0 || req_valid || expected_shadows.size() != 0)
             && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_exponent(logic [PHONG_W-1:0] p);
      csr_write_enable <= 1'b1;
      csr_write_data <= p;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      exponent_q = p;
   endtask

   initial begin
      logic [PHONG_W-1:0] exps[6];
      exps = '{24'd0, 24'hFFFFFF, 24'd256, 24'd5000, 24'd64, 24'd1200000};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes and each special case
      pending_reqs.push_back(vec3(16384, 16384, 16384));
      pending_reqs.push_back(vec3(-16384, -16384, -16384));
      pending_reqs.push_back(vec3(8000, -8000, 8000));
      pending_reqs.push_back(vec3(8000, 8000, -8000));
      pending_reqs.push_back(vec3(8000, -8000, 0));
      pending_reqs.push_back(vec3(8000, 8000, 0));
      pending_reqs.push_back(vec3(8000, 0, 8000));
      pending_reqs.push_back(vec3(16384, 2000, 16384));
      pending_reqs.push_back(vec3(16384, 9000, 16384));
      pending_reqs.push_back(vec3(16384, 16000, 16384));
      pending_reqs.push_back(vec3(-32768, -32768, -32768));
      pending_reqs.push_back(vec3(32767, 32767, 32767));
      pending_reqs.push_back(vec3(16384, 16384, 16384, 16384, 16384));
      pending_reqs.push_back(vec3(-1, 1, -1));
      pending_reqs.push_back('1);
      pending_reqs.push_back('0);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         set_exponent(exps[ph]);
         if (ph == 5) quiet = 1;
         if (ph == 1) begin
            hold_cycles <= 0;
            hold_rsp <= 1;
         end
         for (int i = 0; i < 300; i++) pending_reqs.push_back(rand_req());
         drain();
      end
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+src
src/pshg1_pkg.sv
src/pshg1_front.sv
src/pshg1_divider.sv
src/pshg1_isqrt.sv
src/pshg1_back.sv
src/phong_smith_shadowing_g1_unit.sv
verif/tb_top.sv
